// ===== design/utf8d_pkg.sv =====
// Shared types for the UTF-8 stream decoder.
// Holds the work descriptor passed from the front part to the back part.
// Depends on nothing.
package utf8d_pkg;

    // Most raw results one input byte can cause: three held bytes plus the new one.
    localparam int unsigned RAW_SLOTS = 4;

    // One unit of output work, produced by the front part and drained by the back part.
    // A sequence job yields one decoded code point; a raw job yields raw_count raw bytes.
    typedef struct packed {
        logic                      is_seq;
        logic [20:0]               cp;
        logic [2:0]                seq_len;
        logic [2:0]                raw_count;
        logic [RAW_SLOTS-1:0][7:0] raw;
    } udec_job_t;

endpackage

// ===== design/utf8d_front.sv =====
// Front part of the UTF-8 stream decoder: accepts bytes, tracks the open sequence
// and turns each byte into at most one output job. Depends on utf8d_pkg.
module utf8d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output logic                job_push,
    output utf8d_pkg::udec_job_t job
);
    import utf8d_pkg::*;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] TAIL_MIN   = 8'h80;
    localparam logic [7:0] TAIL_MAX   = 8'hBF;
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] E0_SEC_MIN = 8'hA0;
    localparam logic [7:0] ED_SEC_MAX = 8'h9F;
    localparam logic [7:0] F0_SEC_MIN = 8'h90;
    localparam logic [7:0] F4_SEC_MAX = 8'h8F;
    localparam logic [7:0] TAIL_BITS  = 8'h3F;

    logic [7:0] held_reg [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] exp_len_reg, exp_len_next;

    logic       held_we;
    logic [1:0] held_idx;
    logic       lead_ok;
    logic [2:0] lead_len;
    logic       tail_ok;
    logic [7:0] lead_mask;
    logic       job_valid;

    // Classify the incoming byte as a lead and as a tail.
    always_comb
    begin
        lead_ok = (data_byte >= LEAD_MIN) && (data_byte <= LEAD_MAX);
        if (data_byte <= LEAD2_MAX)
        begin
            lead_len = 3'd2;
        end
        else if (data_byte <= LEAD3_MAX)
        begin
            lead_len = 3'd3;
        end
        else
        begin
            lead_len = 3'd4;
        end

        tail_ok = (data_byte >= TAIL_MIN) && (data_byte <= TAIL_MAX);
        if (held_count_reg == 2'd1)
        begin
            if (held_reg[0] == LEAD_E0 && data_byte < E0_SEC_MIN) tail_ok = 1'b0;
            if (held_reg[0] == LEAD_ED && data_byte > ED_SEC_MAX) tail_ok = 1'b0;
            if (held_reg[0] == LEAD_F0 && data_byte < F0_SEC_MIN) tail_ok = 1'b0;
            if (held_reg[0] == LEAD_MAX && data_byte > F4_SEC_MAX) tail_ok = 1'b0;
        end

        if (exp_len_reg == 3'd2)
        begin
            lead_mask = 8'h1F;
        end
        else if (exp_len_reg == 3'd3)
        begin
            lead_mask = 8'h0F;
        end
        else
        begin
            lead_mask = 8'h07;
        end
    end

    // Decide the next sequence state and the job this byte causes.
    always_comb
    begin
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        held_we         = 1'b0;
        held_idx        = held_count_reg;
        job_valid       = 1'b0;
        job             = '0;

        priority if (held_count_reg == 2'd0)
        begin
            if (lead_ok)
            begin
                held_we         = 1'b1;
                held_idx        = 2'd0;
                held_count_next = 2'd1;
                exp_len_next    = lead_len;
            end
            else
            begin
                job_valid     = 1'b1;
                job.raw_count = 3'd1;
                job.raw[0]    = data_byte;
            end
        end
        else if (tail_ok)
        begin
            if (({1'b0, held_count_reg} + 3'd1) == exp_len_reg)
            begin
                job_valid   = 1'b1;
                job.is_seq  = 1'b1;
                job.seq_len = exp_len_reg;
                unique case (exp_len_reg)
                    3'd2:
                    begin
                        job.cp = {10'd0, held_reg[0][4:0] & lead_mask[4:0],
                                  data_byte[5:0] & TAIL_BITS[5:0]};
                    end
                    3'd3:
                    begin
                        job.cp = {5'd0, held_reg[0][3:0] & lead_mask[3:0],
                                  held_reg[1][5:0] & TAIL_BITS[5:0],
                                  data_byte[5:0] & TAIL_BITS[5:0]};
                    end
                    default:
                    begin
                        job.cp = {held_reg[0][2:0] & lead_mask[2:0],
                                  held_reg[1][5:0] & TAIL_BITS[5:0],
                                  held_reg[2][5:0] & TAIL_BITS[5:0],
                                  data_byte[5:0] & TAIL_BITS[5:0]};
                    end
                endcase
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end
            else
            begin
                held_we         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
            end
        end
        else
        begin
            // Broken sequence: held bytes go raw, plus this byte unless a lead.
            job_valid     = 1'b1;
            job.raw[0]    = held_reg[0];
            job.raw[1]    = (held_count_reg > 2'd1) ? held_reg[1] : data_byte;
            job.raw[2]    = (held_count_reg > 2'd2) ? held_reg[2] : data_byte;
            job.raw[3]    = data_byte;
            if (lead_ok)
            begin
                job.raw_count   = {1'b0, held_count_reg};
                held_we         = 1'b1;
                held_idx        = 2'd0;
                held_count_next = 2'd1;
                exp_len_next    = lead_len;
            end
            else
            begin
                job.raw_count   = {1'b0, held_count_reg} + 3'd1;
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end
        end
    end

    assign job_push = accept && job_valid;

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    // Held lead and tail bytes.
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[held_idx] <= data_byte;
        end
    end

endmodule

// ===== design/utf8d_queue.sv =====
// Short job queue between the front and back parts of the UTF-8 stream decoder.
// Depends on utf8d_pkg.
module utf8d_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8d_pkg::udec_job_t push_job,
    output logic                 full,
    input  logic                 pop,
    output utf8d_pkg::udec_job_t head,
    output logic                 empty
);
    import utf8d_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    udec_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/utf8d_back.sv =====
// Back part of the UTF-8 stream decoder: drains jobs from the queue and emits one
// result per cycle into the output register while result_stall is low. Depends on utf8d_pkg.
module utf8d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8d_pkg::udec_job_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [20:0]          char_code,
    output logic [2:0]           bytes_used,
    output logic                 last_of_run
);
    import utf8d_pkg::*;

    logic        valid_reg;
    logic [20:0] cp_reg;
    logic [2:0]  used_reg;
    logic        last_reg;
    logic [1:0]  idx_reg, idx_next;

    logic        load;
    logic        raw_last;
    logic [20:0] cp_next;
    logic [2:0]  used_next;
    logic        last_next;

    assign load     = !valid_reg || !result_stall;
    assign raw_last = (({1'b0, idx_reg} + 3'd1) == head.raw_count);

    // Select the next result from the job at the head of the queue.
    always_comb
    begin
        pop      = 1'b0;
        idx_next = idx_reg;
        if (head.is_seq)
        begin
            cp_next   = head.cp;
            used_next = head.seq_len;
            last_next = 1'b1;
        end
        else
        begin
            cp_next   = {13'd0, head.raw[idx_reg]};
            used_next = 3'd1;
            last_next = raw_last;
        end
        if (load && !empty)
        begin
            if (head.is_seq || raw_last)
            begin
                pop      = 1'b1;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // Output register and replay index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= !empty;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            cp_reg   <= cp_next;
            used_reg <= used_next;
            last_reg <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign char_code    = cp_reg;
    assign bytes_used   = used_reg;
    assign last_of_run  = last_reg;

endmodule

// ===== design/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: front part, job queue and back part.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
//
// Decodes a UTF-8 byte stream one byte per request. The front part takes a byte in
// every cycle while the job queue (QUEUE_DEPTH entries) has room; the back part emits
// one result per cycle from the output register while result_stall is low. ASCII
// bytes and completed sequences yield one result each, so plain text flows at one
// byte per cycle without output stalls, through the job queue and output register.
// A broken sequence replays its held bytes raw and may add the breaking byte raw:
// that job yields up to four raw results, and input stalls once the queue fills
// behind it. An unfinished sequence stays held; there is no flush at the end of a stream.
module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] char_code,
    output logic [2:0]  bytes_used,
    output logic        last_of_run
);
    import utf8d_pkg::*;

    logic      accept;
    logic      job_push;
    udec_job_t job;
    udec_job_t head;
    logic      queue_full;
    logic      queue_empty;
    logic      pop;

    assign data_stall = queue_full;
    assign accept     = data_valid && !queue_full;

    utf8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .job_push  (job_push),
        .job       (job)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    utf8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_code    (char_code),
        .bytes_used   (bytes_used),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== design/utf8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, attached by a bind statement.
// Depends only on the ports of utf8_stream_decoder.
module utf8d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        data_valid,
    input logic        data_stall,
    input logic [7:0]  data_byte,
    input logic        result_valid,
    input logic        result_stall,
    input logic [20:0] char_code,
    input logic [2:0]  bytes_used,
    input logic        last_of_run
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(char_code)
            && $stable(bytes_used) && $stable(last_of_run))
    else $error("stalled result changed");

    // A decoded multibyte sequence always closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bytes_used != 3'd1 |-> last_of_run)
    else $error("multibyte result not marked last");

    // A raw result is a byte value; a two-byte sequence lies in its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (bytes_used != 3'd1 || char_code <= 21'h0000FF)
            && (bytes_used != 3'd2 || (char_code >= 21'h000080 && char_code <= 21'h0007FF)))
    else $error("code point out of range for its length");

    // Lengths stay within one to four, and code points within Unicode.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> bytes_used >= 3'd1 && bytes_used <= 3'd4
            && char_code <= 21'h10FFFF)
    else $error("result length or code point invalid");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (.*);
